### sv/rsh_pkg.sv
// rsh_pkg: shared types, widths, register codes and helpers for the radial shell histogram
// no dependencies; used by rsh_front, rsh_cell and radial_shell_histogram_top
`default_nettype none

package rsh_pkg;

    localparam int POS_W       = 24;  // Q12.12 coordinate
    localparam int SHL_W       = 6;   // shell index
    localparam int CNT_W       = 32;  // saturating counters
    localparam int MSQ_W       = 48;  // squared 24-bit value
    localparam int D2_W        = 50;  // sum of three squares
    localparam int S2_W        = 12;  // square of the shell count
    localparam int LHS_W       = 62;  // d^2 * S^2, also holds the squared shell bounds
    localparam int DLT_W       = 57;  // bound increment (2j+3) * max_distance^2
    localparam int FRONT_DEPTH = 4;   // stages ahead of the cell chain
    localparam int CFG_IDX_W   = 3;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 72;
    localparam int M_PAD_W     = M_TDATA_W - (SHL_W + 2 * CNT_W);

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHELLS    = 3'd4;

    // request kind carried on tuser
    localparam logic KIND_MOLECULE = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    localparam logic [POS_W-1:0] MAX_DIST_RST = 24'd4096;
    localparam logic [SHL_W-1:0] SHELLS_RST   = 6'd32;

    // molecule token walking the cell chain
    typedef struct packed {
        logic [LHS_W-1:0] lhs;     // d^2 * S^2
        logic [LHS_W-1:0] bnd;     // ((j+1) * max_distance)^2 at cell j
        logic [DLT_W-1:0] dlt;     // (2j+3) * max_distance^2 at cell j
        logic             placed;  // shell already found
        logic [SHL_W-1:0] k;       // shell index once placed
        logic [CNT_W-1:0] cnt;     // shell count after the increment
    } t_tok;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

### sv/rsh_front.sv
// rsh_front: distance pipeline ahead of the cell chain, forms d^2 * S^2 and the first bound
// depends on rsh_pkg
`default_nettype none

module rsh_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_load,
    input  wire logic [rsh_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic [rsh_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic [rsh_pkg::POS_W-1:0]   i_pos_z,
    input  wire logic [rsh_pkg::POS_W-1:0]   i_center_x,
    input  wire logic [rsh_pkg::POS_W-1:0]   i_center_y,
    input  wire logic [rsh_pkg::POS_W-1:0]   i_center_z,
    input  wire logic [rsh_pkg::POS_W-1:0]   i_max_dist,
    input  wire logic [rsh_pkg::SHL_W-1:0]   i_shells,
    output logic                             o_tok_v,
    output rsh_pkg::t_tok                    o_tok,
    output logic [rsh_pkg::DLT_W-1:0]        o_step
);

    logic                         r_v1, r_v2, r_v3, r_v4;
    logic [rsh_pkg::POS_W-1:0]    r_dx, r_dy, r_dz;
    logic [rsh_pkg::MSQ_W-1:0]    r_sx, r_sy, r_sz;
    logic [rsh_pkg::D2_W-1:0]     r_d2;
    logic [rsh_pkg::LHS_W-1:0]    r_lhs;
    logic [rsh_pkg::MSQ_W-1:0]    r_msq;
    logic [rsh_pkg::DLT_W-1:0]    r_msq3;
    logic [rsh_pkg::S2_W-1:0]     r_s2;

    logic [rsh_pkg::MSQ_W-1:0]    n_sx, n_sy, n_sz, n_msq;
    logic [rsh_pkg::D2_W-1:0]     n_d2;
    logic [rsh_pkg::LHS_W-1:0]    n_lhs;
    logic [rsh_pkg::S2_W-1:0]     n_s2;
    logic [rsh_pkg::DLT_W-1:0]    n_msq3;

    assign n_sx   = rsh_pkg::MSQ_W'(r_dx) * rsh_pkg::MSQ_W'(r_dx);
    assign n_sy   = rsh_pkg::MSQ_W'(r_dy) * rsh_pkg::MSQ_W'(r_dy);
    assign n_sz   = rsh_pkg::MSQ_W'(r_dz) * rsh_pkg::MSQ_W'(r_dz);
    assign n_d2   = rsh_pkg::D2_W'(r_sx) + rsh_pkg::D2_W'(r_sy) + rsh_pkg::D2_W'(r_sz);
    assign n_lhs  = rsh_pkg::LHS_W'(r_d2) * rsh_pkg::LHS_W'(r_s2);
    assign n_msq  = rsh_pkg::MSQ_W'(i_max_dist) * rsh_pkg::MSQ_W'(i_max_dist);
    assign n_s2   = rsh_pkg::S2_W'(i_shells) * rsh_pkg::S2_W'(i_shells);
    assign n_msq3 = rsh_pkg::DLT_W'(r_msq) + rsh_pkg::DLT_W'({r_msq, 1'b0});

    // config-derived terms follow the registers continuously
    always_ff @(posedge i_clk) begin
        r_msq  <= n_msq;
        r_msq3 <= n_msq3;
        r_s2   <= n_s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_load;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx  <= rsh_pkg::abs_diff(i_pos_x, i_center_x);
            r_dy  <= rsh_pkg::abs_diff(i_pos_y, i_center_y);
            r_dz  <= rsh_pkg::abs_diff(i_pos_z, i_center_z);
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sz  <= n_sz;
            r_d2  <= n_d2;
            r_lhs <= n_lhs;
        end
    end

    always_comb begin
        o_tok        = '0;
        o_tok.lhs    = r_lhs;
        o_tok.bnd    = rsh_pkg::LHS_W'(r_msq);
        o_tok.dlt    = r_msq3;
        o_tok.placed = 1'b0;
    end

    assign o_tok_v = r_v4;
    assign o_step  = rsh_pkg::DLT_W'({r_msq, 1'b0});

endmodule

`default_nettype wire

### sv/rsh_cell.sv
// rsh_cell: one shell of the chain; holds the shell count, places passing tokens, rotates counts
// depends on rsh_pkg
`default_nettype none

module rsh_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_rot,
    input  wire logic [rsh_pkg::CNT_W-1:0]   i_rot_cnt,
    input  wire logic [rsh_pkg::SHL_W-1:0]   i_shells,
    input  wire logic [rsh_pkg::DLT_W-1:0]   i_step,
    input  wire logic                        i_tok_v,
    input  wire rsh_pkg::t_tok               i_tok,
    output logic                             o_tok_v,
    output rsh_pkg::t_tok                    o_tok,
    output logic [rsh_pkg::CNT_W-1:0]        o_count
);

    logic                       r_tok_v;
    rsh_pkg::t_tok              r_tok;
    logic [rsh_pkg::CNT_W-1:0]  r_count;

    logic                       w_hit;
    logic [rsh_pkg::CNT_W-1:0]  w_inc;
    rsh_pkg::t_tok              n_tok;

    // molecule lands here when this is the overflow shell or the next bound lies beyond it
    assign w_hit = i_tok_v && !i_tok.placed &&
                   ((rsh_pkg::SHL_W'(CELL_IDX) == i_shells) || (i_tok.bnd > i_tok.lhs));
    assign w_inc = rsh_pkg::sat_inc(r_count);

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.placed = 1'b1;
            n_tok.k      = rsh_pkg::SHL_W'(CELL_IDX);
            n_tok.cnt    = w_inc;
        end else if (!i_tok.placed) begin
            n_tok.bnd = i_tok.bnd + rsh_pkg::LHS_W'(i_tok.dlt);
            n_tok.dlt = i_tok.dlt + i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_v <= 1'b0;
            r_count <= '0;
        end else if (i_adv) begin
            r_tok_v <= i_tok_v;
            if (i_rot) begin
                r_count <= i_rot_cnt;
            end else if (w_hit) begin
                r_count <= w_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok_v = r_tok_v;
    assign o_tok   = r_tok;
    assign o_count = r_count;

endmodule

`default_nettype wire

### sv/radial_shell_histogram_top.sv
// radial_shell_histogram_top: config registers, distance pipeline, shell cell chain, output register
// depends on rsh_pkg, rsh_front, rsh_cell
//
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   i_s_tdata {pos_z, pos_y, pos_x}, i_s_tuser kind
// m         out  o_m_tvalid / i_m_tready   o_m_tdata {pad, sample_count, shell_count,
//                                            shell_index}, o_m_tlast last
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a molecule passes 4 distance stages, then the SHELL_SLOTS-cell chain, then the output register;
// molecules enter one per cycle unless the output stalls or a snapshot is pending or active.
// an end-of-snapshot request waits until no molecule is in flight, then rotates the counts once
// around the chain, reporting shells 0..S one per cycle from cell 0 unless the output stalls.
// a stall on the output side freezes the whole pipeline and chain; reset clears all counts.
`default_nettype none

module radial_shell_histogram_top #(
    parameter int SHELL_SLOTS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [rsh_pkg::S_TDATA_W-1:0]     i_s_tdata,   // pos_x, pos_y, pos_z
    input  wire logic                              i_s_tuser,   // kind
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [rsh_pkg::M_TDATA_W-1:0]          o_m_tdata,   // shell_index, shell_count,
                                                                // sample_count, zero pad
    output logic                                   o_m_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rsh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rsh_pkg::POS_W-1:0]         i_cfg_data
);

    localparam int IDX_W = $clog2(SHELL_SLOTS);
    localparam int IF_W  = $clog2(SHELL_SLOTS + rsh_pkg::FRONT_DEPTH + 1);
    localparam int POS_W = rsh_pkg::POS_W;
    localparam int SHL_W = rsh_pkg::SHL_W;
    localparam int CNT_W = rsh_pkg::CNT_W;

    // configuration registers
    logic [POS_W-1:0] r_center_x, r_center_y, r_center_z, r_max_dist;
    logic [SHL_W-1:0] r_shells;
    logic [SHL_W-1:0] w_shells;

    // control
    logic              r_snap_pend, r_snap_act;
    logic [IDX_W-1:0]  r_snap_idx;
    logic [CNT_W-1:0]  r_snapshots;
    logic [IF_W-1:0]   r_inflight;
    logic [IF_W-1:0]   n_inflight;

    // output register
    logic              r_out_valid;
    logic [SHL_W-1:0]  r_out_idx;
    logic [CNT_W-1:0]  r_out_cnt, r_out_smp;
    logic              r_out_last;

    logic w_adv, w_acc, w_mol_acc, w_snap_acc, w_tail_out, w_emit_snap, w_snap_start, w_rot;

    logic                       w_front_v;
    rsh_pkg::t_tok              w_front_tok;
    logic [rsh_pkg::DLT_W-1:0]  w_step;

    logic [SHELL_SLOTS-1:0]     w_tok_v;
    rsh_pkg::t_tok              w_tok   [SHELL_SLOTS];
    logic [CNT_W-1:0]           w_count [SHELL_SLOTS];

    assign w_shells = (r_shells > SHL_W'(SHELL_SLOTS - 1)) ? SHL_W'(SHELL_SLOTS - 1) : r_shells;

    assign w_adv        = !r_out_valid || i_m_tready;
    assign o_s_tready   = w_adv && !r_snap_pend && !r_snap_act;
    assign w_acc        = i_s_tvalid && o_s_tready;
    assign w_mol_acc    = w_acc && (i_s_tuser == rsh_pkg::KIND_MOLECULE);
    assign w_snap_acc   = w_acc && (i_s_tuser == rsh_pkg::KIND_SNAPSHOT);
    assign w_tail_out   = w_adv && w_tok_v[SHELL_SLOTS-1];
    assign w_snap_start = r_snap_pend && (r_inflight == '0);
    assign w_rot        = r_snap_act && w_adv;
    assign w_emit_snap  = w_rot && (SHL_W'(r_snap_idx) <= w_shells);
    assign n_inflight   = r_inflight + IF_W'(w_mol_acc) - IF_W'(w_tail_out);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_max_dist <= rsh_pkg::MAX_DIST_RST;
            r_shells   <= rsh_pkg::SHELLS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rsh_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                rsh_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                rsh_pkg::CFG_CENTER_Z: r_center_z <= i_cfg_data;
                rsh_pkg::CFG_MAX_DIST: r_max_dist <= i_cfg_data;
                rsh_pkg::CFG_SHELLS:   r_shells   <= i_cfg_data[SHL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_pend <= 1'b0;
            r_snap_act  <= 1'b0;
            r_snap_idx  <= '0;
            r_snapshots <= '0;
            r_inflight  <= '0;
        end else begin
            r_inflight <= n_inflight;
            if (w_snap_acc) begin
                r_snap_pend <= 1'b1;
            end
            if (w_snap_start) begin
                // older molecules have all left, so they report the old snapshot count
                r_snap_pend <= 1'b0;
                r_snap_act  <= 1'b1;
                r_snap_idx  <= '0;
                r_snapshots <= rsh_pkg::sat_inc(r_snapshots);
            end else if (w_rot) begin
                r_snap_idx <= r_snap_idx + IDX_W'(1);
                if (r_snap_idx == IDX_W'(SHELL_SLOTS - 1)) begin
                    r_snap_act <= 1'b0;
                end
            end
        end
    end

    rsh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_load     (w_mol_acc),
        .i_pos_x    (i_s_tdata[POS_W-1:0]),
        .i_pos_y    (i_s_tdata[2*POS_W-1:POS_W]),
        .i_pos_z    (i_s_tdata[3*POS_W-1:2*POS_W]),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_max_dist (r_max_dist),
        .i_shells   (w_shells),
        .o_tok_v    (w_front_v),
        .o_tok      (w_front_tok),
        .o_step     (w_step)
    );

    for (genvar g = 0; g < SHELL_SLOTS; g++) begin : g_cell
        logic               w_in_v;
        rsh_pkg::t_tok      w_in_tok;
        logic [CNT_W-1:0]   w_next_cnt;

        if (g == 0) begin : g_head
            assign w_in_v   = w_front_v;
            assign w_in_tok = w_front_tok;
        end else begin : g_body
            assign w_in_v   = w_tok_v[g-1];
            assign w_in_tok = w_tok[g-1];
        end

        // counts rotate toward cell 0 during a snapshot report
        if (g == SHELL_SLOTS - 1) begin : g_wrap
            assign w_next_cnt = w_count[0];
        end else begin : g_link
            assign w_next_cnt = w_count[g+1];
        end

        rsh_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_rot     (w_rot),
            .i_rot_cnt (w_next_cnt),
            .i_shells  (w_shells),
            .i_step    (w_step),
            .i_tok_v   (w_in_v),
            .i_tok     (w_in_tok),
            .o_tok_v   (w_tok_v[g]),
            .o_tok     (w_tok[g]),
            .o_count   (w_count[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tok_v[SHELL_SLOTS-1] || w_emit_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_tok_v[SHELL_SLOTS-1]) begin
                r_out_idx  <= w_tok[SHELL_SLOTS-1].k;
                r_out_cnt  <= w_tok[SHELL_SLOTS-1].cnt;
                r_out_smp  <= r_snapshots;
                r_out_last <= 1'b1;
            end else begin
                r_out_idx  <= SHL_W'(r_snap_idx);
                r_out_cnt  <= w_count[0];
                r_out_smp  <= r_snapshots;
                r_out_last <= (SHL_W'(r_snap_idx) == w_shells);
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{rsh_pkg::M_PAD_W{1'b0}}, r_out_smp, r_out_cnt, r_out_idx};
    assign o_m_tlast  = r_out_last;

    // counts may only rotate while the chain holds no molecule
    a_rot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_act |-> (r_inflight == '0 && w_tok_v == '0 && !w_front_v))
        else $error("count rotation with molecules in flight");

    a_snap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_snap_pend && r_snap_act))
        else $error("snapshot pending while another is reported");

    a_inflight_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= IF_W'(SHELL_SLOTS + rsh_pkg::FRONT_DEPTH))
        else $error("in-flight count beyond pipeline capacity");

    a_tail_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_v[SHELL_SLOTS-1] |-> w_tok[SHELL_SLOTS-1].placed)
        else $error("molecule left the chain without a shell");

endmodule

`default_nettype wire

### dv/rsh_checker.sv
`timescale 1ns / 1ps
// rsh_checker: watches the config, molecule and shell output channels of the radial shell
// histogram, predicts every output request and compares it field by field; depends on rsh_pkg

module rsh_checker #(
    parameter int SHELL_SLOTS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    input  wire logic [rsh_pkg::S_TDATA_W-1:0]     i_s_tdata,   // pos_x, pos_y, pos_z
    input  wire logic                              i_s_tuser,   // kind
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [rsh_pkg::M_TDATA_W-1:0]     i_m_tdata,   // shell_index, shell_count,
                                                                // sample_count, zero pad
    input  wire logic                              i_m_tlast,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              i_cfg_ready,
    input  wire logic [rsh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rsh_pkg::POS_W-1:0]         i_cfg_data,
    output int                                     o_mismatches,
    output int                                     o_reports_due
);

    localparam int POS_W     = rsh_pkg::POS_W;
    localparam int SHL_W     = rsh_pkg::SHL_W;
    localparam int CNT_W     = rsh_pkg::CNT_W;
    localparam int S_TDATA_W = rsh_pkg::S_TDATA_W;

    typedef struct packed {
        logic [SHL_W-1:0] shell;
        logic [CNT_W-1:0] shell_count;
        logic [CNT_W-1:0] sample_count;
        logic             last;
    } t_shell_report;

    t_shell_report    reports_due[$];
    t_shell_report    want;
    t_shell_report    got;
    logic [CNT_W-1:0] shell_tally [SHELL_SLOTS];
    logic [CNT_W-1:0] snapshot_tally;
    logic [POS_W-1:0] center [3];
    logic [POS_W-1:0] radius;
    logic [SHL_W-1:0] shells_cfg;
    int               shells_now;
    int               hit;

    task automatic report_mismatch(input string msg);
        o_mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // the overflow shell needs a slot of its own
    function automatic int regular_shells();
        return (int'(shells_cfg) > SHELL_SLOTS - 1) ? SHELL_SLOTS - 1 : int'(shells_cfg);
    endfunction

    // shell k is the largest j <= S with (j * radius)^2 <= d^2 * S^2
    function automatic int locate_shell(input logic [S_TDATA_W-1:0] coords);
        logic [POS_W-1:0] p;
        bit [63:0]        dd;
        bit [63:0]        d2;
        bit [63:0]        lhs;
        bit [63:0]        bnd;
        int               s;
        int               k;
        s  = regular_shells();
        d2 = 0;
        for (int a = 0; a < 3; a++) begin
            p  = coords[a*POS_W +: POS_W];
            dd = (p >= center[a]) ? 64'(p - center[a]) : 64'(center[a] - p);
            d2 = d2 + dd * dd;
        end
        lhs = d2 * 64'(s) * 64'(s);
        k   = 0;
        // bounds grow with j, so the last one that fits wins
        for (int j = 1; j <= s; j++) begin
            bnd = 64'(j) * 64'(radius);
            if (bnd * bnd <= lhs)
                k = j;
        end
        return k;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SHELL_SLOTS; j++)
                shell_tally[j] = '0;
            snapshot_tally = '0;
            center[0]      = '0;
            center[1]      = '0;
            center[2]      = '0;
            radius         = rsh_pkg::MAX_DIST_RST;
            shells_cfg     = rsh_pkg::SHELLS_RST;
            reports_due.delete();
            o_mismatches   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.shell        = i_m_tdata[SHL_W-1:0];
                got.shell_count  = i_m_tdata[SHL_W +: CNT_W];
                got.sample_count = i_m_tdata[SHL_W + CNT_W +: CNT_W];
                got.last         = i_m_tlast;
                if (reports_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected report for shell %0d", got.shell));
                end else begin
                    want = reports_due.pop_front();
                    if (got.shell !== want.shell)
                        report_mismatch($sformatf("shell_index got %0d want %0d",
                                                  got.shell, want.shell));
                    if (got.shell_count !== want.shell_count)
                        report_mismatch($sformatf("shell_count got %0d want %0d (shell %0d)",
                                                  got.shell_count, want.shell_count,
                                                  want.shell));
                    if (got.sample_count !== want.sample_count)
                        report_mismatch($sformatf("sample_count got %0d want %0d (shell %0d)",
                                                  got.sample_count, want.sample_count,
                                                  want.shell));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b (shell %0d)",
                                                  got.last, want.last, want.shell));
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                shells_now = regular_shells();
                if (i_s_tuser == rsh_pkg::KIND_SNAPSHOT) begin
                    snapshot_tally = bump(snapshot_tally);
                    for (int j = 0; j <= shells_now; j++) begin
                        want.shell        = SHL_W'(j);
                        want.shell_count  = shell_tally[j];
                        want.sample_count = snapshot_tally;
                        want.last         = (j == shells_now);
                        reports_due.push_back(want);
                    end
                end else begin
                    hit              = locate_shell(i_s_tdata);
                    shell_tally[hit] = bump(shell_tally[hit]);
                    want.shell        = SHL_W'(hit);
                    want.shell_count  = shell_tally[hit];
                    want.sample_count = snapshot_tally;
                    want.last         = 1'b1;
                    reports_due.push_back(want);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rsh_pkg::CFG_CENTER_X: center[0]  = i_cfg_data;
                    rsh_pkg::CFG_CENTER_Y: center[1]  = i_cfg_data;
                    rsh_pkg::CFG_CENTER_Z: center[2]  = i_cfg_data;
                    rsh_pkg::CFG_MAX_DIST: radius     = i_cfg_data;
                    rsh_pkg::CFG_SHELLS:   shells_cfg = i_cfg_data[SHL_W-1:0];
                    default: ;
                endcase
            end
        end
        o_reports_due = reports_due.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset and stimulus for radial_shell_histogram_top, with rsh_checker beside it
// depends on rsh_pkg, rsh_checker and the histogram RTL

module tb_top;

    localparam int               POS_W           = rsh_pkg::POS_W;
    localparam int               SHL_W           = rsh_pkg::SHL_W;
    localparam int               CFG_IDX_W       = rsh_pkg::CFG_IDX_W;
    localparam int               S_TDATA_W       = rsh_pkg::S_TDATA_W;
    localparam int               M_TDATA_W       = rsh_pkg::M_TDATA_W;
    localparam int               SLOTS           = 64;
    localparam logic             MOLECULE        = rsh_pkg::KIND_MOLECULE;
    localparam logic             END_OF_SNAPSHOT = rsh_pkg::KIND_SNAPSHOT;
    localparam logic [POS_W-1:0] POS_MAX         = '1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [POS_W-1:0]     i_cfg_data  = '0;
    wire                  o_s_tready;
    wire                  o_m_tvalid;
    wire [M_TDATA_W-1:0]  o_m_tdata;
    wire                  o_m_tlast;
    wire                  o_cfg_ready;
    int                   mismatches;
    int                   reports_due;

    // no idling on either side while set
    bit                   steady = 1'b0;

    // current setting, used only to aim positions at the shells
    logic [POS_W-1:0]     cur_center [3];
    logic [POS_W-1:0]     cur_radius = rsh_pkg::MAX_DIST_RST;
    logic [SHL_W-1:0]     cur_shells = rsh_pkg::SHELLS_RST;

    radial_shell_histogram_top #(
        .SHELL_SLOTS (SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rsh_checker #(
        .SHELL_SLOTS (SLOTS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_reports_due (reports_due)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= 14);
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic kind, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz);
        while (!steady && $urandom_range(0, 99) < 14) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {pz, py, px};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy,
                                input logic [POS_W-1:0] cz, input logic [POS_W-1:0] rad,
                                input logic [POS_W-1:0] shells, input bit stray);
        write_reg(rsh_pkg::CFG_CENTER_X, cx);
        write_reg(rsh_pkg::CFG_CENTER_Y, cy);
        write_reg(rsh_pkg::CFG_CENTER_Z, cz);
        write_reg(rsh_pkg::CFG_MAX_DIST, rad);
        write_reg(rsh_pkg::CFG_SHELLS, shells);
        // indexes past the last register must leave everything alone
        if (stray)
            write_reg(rsh_pkg::CFG_SHELLS + CFG_IDX_W'($urandom_range(1, 3)),
                      POS_W'($urandom));
        i_cfg_valid   <= 1'b0;
        cur_center[0] = cx;
        cur_center[1] = cy;
        cur_center[2] = cz;
        cur_radius    = rad;
        cur_shells    = shells[SHL_W-1:0];
        @(posedge i_clk);
    endtask

    // drain every report, then give the snapshot sweep time to finish
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reports_due != 0) @(posedge i_clk);
        repeat (SLOTS + 10) @(posedge i_clk);
    endtask

    task automatic close_phase();
        send_item(END_OF_SNAPSHOT, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        settle();
    endtask

    function automatic logic [POS_W-1:0] nudge(input logic [POS_W-1:0] base,
                                               input longint off);
        longint p;
        p = longint'(base) + (($urandom_range(0, 1) == 1) ? off : -off);
        if (p < 0)
            p = 0;
        else if (p > longint'(POS_MAX))
            p = longint'(POS_MAX);
        return POS_W'(p);
    endfunction

    // mostly positions around the center, some right on a shell bound, some anywhere
    task automatic random_items(input int n);
        int unsigned      pick;
        int unsigned      span;
        int unsigned      hop;
        int unsigned      shell_pick;
        logic [2:0]       axes;
        logic [POS_W-1:0] pos [3];
        repeat (n) begin
            pick       = $urandom_range(0, 99);
            axes       = 3'($urandom);
            span       = (cur_radius > 24'hCCCCCC) ? 32'(POS_MAX)
                                                   : 32'(cur_radius) + 32'(cur_radius) / 4 + 1;
            shell_pick = $urandom_range(0, 32'(cur_shells) + 1);
            hop        = (cur_shells == 0) ? 32'(cur_radius)
                                           : (shell_pick * 32'(cur_radius)) / 32'(cur_shells);
            for (int a = 0; a < 3; a++) begin
                if (pick < 25)
                    pos[a] = POS_W'($urandom);
                else if (pick < 40)
                    pos[a] = (a == 0) ? nudge(cur_center[0], longint'(hop) +
                                              longint'($urandom_range(0, 2)) - 1)
                                      : cur_center[a];
                else
                    pos[a] = axes[a] ? nudge(cur_center[a], longint'($urandom_range(0, span)))
                                     : cur_center[a];
            end
            if (pick < 8)
                send_item(END_OF_SNAPSHOT, pos[0], pos[1], pos[2]);
            else
                send_item(MOLECULE, pos[0], pos[1], pos[2]);
        end
    endtask

    initial begin
        cur_center[0] = '0;
        cur_center[1] = '0;
        cur_center[2] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: center at origin, radius 1.0, 32 shells of 128 lsb each
        send_item(MOLECULE, '0, '0, '0);
        send_item(MOLECULE, 24'd127, '0, '0);
        send_item(MOLECULE, 24'd128, '0, '0);
        send_item(MOLECULE, 24'd4095, '0, '0);
        send_item(MOLECULE, '0, '0, 24'd4096);
        send_item(MOLECULE, POS_MAX, POS_MAX, POS_MAX);
        close_phase();

        // widest radius, most shells
        load_setting(24'h800000, 24'h800000, 24'h800000, POS_MAX, 24'd63, 1'b0);
        send_item(MOLECULE, '0, '0, '0);
        send_item(MOLECULE, POS_MAX, POS_MAX, POS_MAX);
        random_items(25);
        close_phase();

        // one shell one lsb wide, center in the far corner
        load_setting(POS_MAX, POS_MAX, POS_MAX, 24'd1, 24'd1, 1'b0);
        send_item(MOLECULE, POS_MAX, POS_MAX, POS_MAX);
        send_item(MOLECULE, POS_MAX - 24'd1, POS_MAX, POS_MAX);
        random_items(15);
        close_phase();

        // zero radius puts everything in the overflow shell
        load_setting('0, '0, '0, '0, 24'd5, 1'b1);
        send_item(MOLECULE, '0, '0, '0);
        send_item(MOLECULE, 24'd1, '0, '0);
        steady = 1'b1;
        random_items(25);
        steady = 1'b0;
        close_phase();

        // upper bits dropped by the shell register: zero shells
        load_setting(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     POS_W'($urandom_range(1, 24'h20000)), 24'hFFFFC0, 1'b1);
        send_item(MOLECULE, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        random_items(10);
        close_phase();

        load_setting(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     POS_W'($urandom_range(1, 24'h3000)), POS_W'($urandom_range(1, 63)), 1'b0);
        random_items(20);
        close_phase();

        load_setting(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                     POS_W'($urandom), POS_W'($urandom), 1'b1);
        random_items(15);
        close_phase();

        if (mismatches == 0 && reports_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
